FILE: src/irdx_pkg.sv
`timescale 1ns / 1ps

package irdx_pkg;

   localparam int VALUE_W     = 32;
   localparam int BASE_W      = 9;
   localparam int DIGIT_W     = 8;
   localparam int COUNT_W     = 5;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 16;

   localparam logic [BASE_W-1:0] BASE_MIN   = 9'd2;
   localparam logic [BASE_W-1:0] BASE_MAX   = 9'd256;
   localparam logic [BASE_W-1:0] BASE_RESET = 9'd256;

   // quotient bits retired per divider cycle
   localparam int DIV_BITS   = 4;
   localparam int DIV_CYCLES = VALUE_W / DIV_BITS;

   typedef struct packed {
      logic               start;
      logic [VALUE_W-1:0] dividend;
      logic [BASE_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [VALUE_W-1:0] quotient;
      logic [DIGIT_W-1:0] remainder;
   } div_rsp_type;

endpackage

FILE: src/irdx_ram.sv
`timescale 1ns / 1ps

module irdx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 31
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/irdx_div.sv
`timescale 1ns / 1ps

module irdx_div (
   input  logic                 clock,
   input  logic                 reset,
   input  irdx_pkg::div_req_type div_req,
   output irdx_pkg::div_rsp_type div_rsp
);

   import irdx_pkg::*;

   localparam int STEP_W = $clog2(DIV_CYCLES);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [VALUE_W-1:0]  quo_ff, quo_in;
   logic [DIGIT_W-1:0]  rem_ff, rem_in;
   logic [BASE_W-1:0]   dvs_ff, dvs_in;
   logic [VALUE_W-1:0]  quo_nxt;
   logic [DIGIT_W-1:0]  rem_nxt;

   // restoring division, DIV_BITS quotient bits per cycle
   always_comb begin
      logic [BASE_W-1:0] trial;
      quo_nxt = quo_ff;
      rem_nxt = rem_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial   = {rem_nxt, quo_nxt[VALUE_W-1]};
         quo_nxt = {quo_nxt[VALUE_W-2:0], 1'b0};
         if (trial >= dvs_ff) begin
            trial      = trial - dvs_ff;
            quo_nxt[0] = 1'b1;
         end
         rem_nxt = trial[DIGIT_W-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (busy_ff) begin
         quo_in  = quo_nxt;
         rem_in  = rem_nxt;
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

FILE: src/integer_to_radix_digits.sv
`timescale 1ns / 1ps
// Sequence: each digit comes from the shared radix divider (8 steps of 4 quotient bits)
// and is written to the digit store; each digit is then read from the digit store and
// loaded into the output register once it is free. A new item is taken only in idle,
// after the last digit is loaded. Digit count 1..MAX_DIGITS; a non-positive value gives 0.
// Reset: synchronous, active high; clears the sequencer and output valid, base = 256.

module integer_to_radix_digits #(
   parameter int MAX_DIGITS = 31
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [irdx_pkg::BASE_W-1:0]         csr_wr_data,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [irdx_pkg::REQ_TDATA_W-1:0]    req_tdata,   // [31:0] value
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [irdx_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // [7:0] digit, [12:8] digit_count
   output logic                                rsp_tlast    // last
);

   import irdx_pkg::*;

   localparam int AW = $clog2(MAX_DIGITS);
   localparam int CW = $clog2(MAX_DIGITS + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_LOAD = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [AW-1:0]       rd_idx_ff, rd_idx_in;
   logic                out_vld_ff, out_vld_in;
   logic [DIGIT_W-1:0]  digit_ff, digit_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                last_ff, last_in;

   logic [BASE_W-1:0]   eff_base;
   logic [CW-1:0]       cnt_m1;
   logic [31:0]         cnt_ext;
   logic                req_acc;
   logic                positive;
   logic                cnt_full;
   logic                out_free;
   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [DIGIT_W-1:0]  ram_wdata;
   logic [DIGIT_W-1:0]  ram_rdata;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   assign eff_base = (base_ff < BASE_MIN) ? BASE_MIN :
                     (base_ff > BASE_MAX) ? BASE_MAX : base_ff;
   assign base_in  = csr_wr_en ? csr_wr_data : base_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign positive   = !req_tdata[VALUE_W-1] && (req_tdata != '0);
   assign cnt_full   = (cnt_ff >= CW'(MAX_DIGITS));
   assign cnt_m1     = cnt_ff - CW'(1);
   assign cnt_ext    = 32'(cnt_ff);
   assign out_free   = !out_vld_ff || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      rd_idx_in  = rd_idx_ff;
      out_vld_in = out_vld_ff && !rsp_tready;
      digit_in   = digit_ff;
      count_in   = count_ff;
      last_in    = last_ff;
      ram_we     = 1'b0;
      ram_waddr  = cnt_ff[AW-1:0];
      ram_wdata  = div_rsp.remainder;
      div_req.start    = 1'b0;
      div_req.dividend = req_tdata;
      div_req.divisor  = eff_base;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (positive) begin
                  div_req.start = 1'b1;
                  cnt_in        = '0;
                  state_in      = S_DIV;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = '0;
                  cnt_in    = CW'(1);
                  rd_idx_in = '0;
                  state_in  = S_READ;
               end
            end
         end
         S_DIV: begin
            div_req.dividend = div_rsp.quotient;
            if (div_rsp.done) begin
               // higher digits beyond the store are dropped
               if (!cnt_full) begin
                  ram_we = 1'b1;
                  cnt_in = cnt_ff + CW'(1);
               end
               if (div_rsp.quotient != '0) begin
                  div_req.start = 1'b1;
               end else begin
                  rd_idx_in = cnt_full ? cnt_m1[AW-1:0] : cnt_ff[AW-1:0];
                  state_in  = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               digit_in   = ram_rdata;
               count_in   = cnt_ext[COUNT_W-1:0];
               last_in    = (rd_idx_ff == '0);
               if (rd_idx_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff - AW'(1);
                  state_in  = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         base_ff    <= BASE_RESET;
         out_vld_ff <= 1'b0;
         cnt_ff     <= '0;
         rd_idx_ff  <= '0;
      end else begin
         state_ff   <= state_in;
         base_ff    <= base_in;
         out_vld_ff <= out_vld_in;
         cnt_ff     <= cnt_in;
         rd_idx_ff  <= rd_idx_in;
      end
      digit_ff <= digit_in;
      count_ff <= count_in;
      last_ff  <= last_in;
   end

   irdx_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   irdx_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (MAX_DIGITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - COUNT_W - DIGIT_W)'(0), count_ff, digit_ff};
   assign rsp_tlast  = last_ff;

endmodule

FILE: src/irdx_chk.sv
`timescale 1ns / 1ps

module irdx_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                csr_wr_en,
   input logic [irdx_pkg::BASE_W-1:0]         csr_wr_data,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [irdx_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [irdx_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input logic                                rsp_tlast
);

   import irdx_pkg::*;

   logic [COUNT_W-1:0] rsp_count;
   assign rsp_count = rsp_tdata[DIGIT_W +: COUNT_W];

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item taken while a conversion is in progress");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_count != '0)
      else $error("digit count of zero");

   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_count == COUNT_W'(1)) |-> rsp_tlast)
      else $error("single digit run without last");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result dropped or changed");

endmodule

bind integer_to_radix_digits irdx_chk u_chk (.*);
